>>> design/bta_pkg.sv
// ----------------------------------------------------------------------------
// bta_pkg
// Shared types and constants of the buddy tree allocator: sequencer states,
// node status codes, result status codes and configuration register indexes.
// ----------------------------------------------------------------------------
package bta_pkg;

   // Default number of tree levels below the root.
   localparam int LEVELS_DEF = 8;

   // Configuration register indexes and reset values.
   localparam logic [1:0] CSR_POOL_LOG2 = 2'd0;
   localparam logic [1:0] CSR_LEAF_LOG2 = 2'd1;
   localparam logic [5:0] POOL_LOG2_RST = 6'd16;
   localparam logic [5:0] LEAF_LOG2_RST = 6'd8;

   // Request actions.
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // Per-node status held in the tree memory.
   typedef enum logic [1:0] {
      NODE_FREE  = 2'd0,
      NODE_SPLIT = 2'd1,
      NODE_OCC   = 2'd2,
      NODE_CHOCC = 2'd3
   } node_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NO_SPACE  = 2'd1,
      STAT_TOO_LARGE = 2'd2,
      STAT_BAD_FREE  = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_SIZE,
      S_A_RD,
      S_A_EVAL,
      S_A_FREE,
      S_A_WR_L,
      S_A_WR_R,
      S_A_UP,
      S_A_CHK_RD,
      S_A_CHK,
      S_F_RD,
      S_F_EVAL,
      S_F_UP_RD,
      S_F_UP,
      S_FINISH
   } state_type;

endpackage

>>> design/buddy_tree_allocator.sv
// ----------------------------------------------------------------------------
// buddy_tree_allocator
// Binary buddy allocator whose tree of node states lives in a small memory
// and is walked by a sequencer.
// ----------------------------------------------------------------------------
// One transaction at a time: the single tree memory port set and the node
// sequencer serve one walk, and requests are stalled until it has finished.
// Reset (and every configuration write to a known index) starts a clearing
// pass that marks all 2^(LEVELS+1)-1 nodes free; no request is taken then.
// ----------------------------------------------------------------------------
module buddy_tree_allocator #(
   parameter int LEVELS = bta_pkg::LEVELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [31:0] req_request_size,
   input  logic [31:0] req_block_offset,
   // Response channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_offset,
   output logic [31:0] rsp_block_bytes,
   // Configuration write port.
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [5:0]  csr_wdata
);

   // Node index width, node count (heap order) and depth counter width.
   localparam int IW    = LEVELS + 1;
   localparam int NODES = (1 << IW) - 1;
   localparam int DW    = $clog2(LEVELS + 1);
   localparam logic [DW-1:0] LEVELS_D = DW'(LEVELS);
   localparam logic [IW-1:0] LAST_IDX = IW'(NODES - 1);

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   bta_pkg::state_type  state_ff, state_in;
   logic [5:0]          pool_log2_ff, pool_log2_in;
   logic [5:0]          leaf_log2_ff, leaf_log2_in;
   logic [IW-1:0]       clr_ff, clr_in;

   // The request being worked on.
   logic                action_ff, action_in;
   logic [31:0]         size_ff, size_in;
   logic [31:0]         target_ff, target_in;
   logic [5:0]          k_ff, k_in;

   // Current node of the walk: index, depth, log2 of its size, byte offset.
   logic [IW-1:0]       idx_ff, idx_in;
   logic [DW-1:0]       dep_ff, dep_in;
   logic [5:0]          nlog_ff, nlog_in;
   logic [31:0]         base_ff, base_in;

   // First free node met by an allocation; unwinding resumes from it.
   logic [IW-1:0]       sv_idx_ff, sv_idx_in;
   logic [DW-1:0]       sv_dep_ff, sv_dep_in;
   logic [5:0]          sv_nlog_ff, sv_nlog_in;
   logic [31:0]         sv_base_ff, sv_base_in;

   logic                got_ff, got_in;
   bta_pkg::node_type   cst_ff, cst_in;

   // Result staged until the response register is free.
   bta_pkg::status_type res_status_ff, res_status_in;
   logic [31:0]         res_offset_ff, res_offset_in;
   logic [31:0]         res_bytes_ff, res_bytes_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [31:0]         rsp_offset_ff, rsp_offset_in;
   logic [31:0]         rsp_block_bytes_ff, rsp_block_bytes_in;

   // ------------------------------------------------------------------------
   // Tree memory: one write port and two registered read ports.
   // ------------------------------------------------------------------------
   bta_pkg::node_type   node_mem [NODES];
   bta_pkg::node_type   rd_a_ff, rd_b_ff;
   logic [IW-1:0]       rd_a_addr, rd_b_addr;
   logic                mem_we;
   logic [IW-1:0]       mem_wa;
   bta_pkg::node_type   mem_wd;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem[mem_wa] <= mem_wd;
      end
      rd_a_ff <= node_mem[rd_a_addr];
      rd_b_ff <= node_mem[rd_b_addr];
   end

   // ------------------------------------------------------------------------
   // Pool geometry from the configuration registers. The pool size is held
   // between 2 and 2^32 bytes, and the leaf size is kept within LEVELS
   // levels below the pool and never above it.
   // ------------------------------------------------------------------------
   logic [5:0] geo_pool, geo_leaf;

   always_comb begin
      geo_pool = pool_log2_ff;
      if (pool_log2_ff == 6'd0) begin
         geo_pool = 6'd1;
      end else if (pool_log2_ff > 6'd32) begin
         geo_pool = 6'd32;
      end
      geo_leaf = leaf_log2_ff;
      if (({1'b0, leaf_log2_ff} + 7'(LEVELS)) < {1'b0, geo_pool}) begin
         geo_leaf = geo_pool - 6'(LEVELS);
      end
      if (geo_leaf > geo_pool) begin
         geo_leaf = geo_pool;
      end
   end

   // ------------------------------------------------------------------------
   // Node arithmetic around the current node.
   // ------------------------------------------------------------------------
   logic [IW-1:0] left_idx, right_idx, parent_idx, sib_idx;
   logic [31:0]   node_bit, half_bit;
   logic [31:0]   eff_size;
   logic [31:0]   node_bytes;
   logic          want_split, at_bottom, tgt_bit;
   logic          rd_a_full, rd_b_full;

   always_comb begin
      left_idx   = {idx_ff[IW-2:0], 1'b1};
      right_idx  = left_idx + IW'(1);
      parent_idx = (idx_ff - IW'(1)) >> 1;
      sib_idx    = idx_ff[0] ? (idx_ff + IW'(1)) : (idx_ff - IW'(1));
      node_bit   = 32'd1 << nlog_ff[4:0];
      half_bit   = 32'd1 << 5'(nlog_ff - 6'd1);
      tgt_bit    = target_ff[5'(nlog_ff - 6'd1)];
      eff_size   = (size_ff == 32'd0) ? 32'd1 : size_ff;
      node_bytes = (nlog_ff >= 6'd32) ? 32'hFFFF_FFFF : node_bit;
      want_split = nlog_ff > k_ff;
      at_bottom  = dep_ff == LEVELS_D;
      rd_a_full  = (rd_a_ff == bta_pkg::NODE_OCC) || (rd_a_ff == bta_pkg::NODE_CHOCC);
      rd_b_full  = (rd_b_ff == bta_pkg::NODE_OCC) || (rd_b_ff == bta_pkg::NODE_CHOCC);
   end

   // ------------------------------------------------------------------------
   // Sequencer.
   // An allocation walks the tree depth first, left child first, through
   // split nodes. A free node ends the descent: it is split level by level
   // down to the wanted size and the last one is marked occupied. Unwinding
   // then climbs back, trying the right child where the left one failed and
   // marking a parent whose children are both full.
   // A free descends by offset to the occupied node, frees it and climbs,
   // merging free buddies and marking parents split until nothing changes.
   // ------------------------------------------------------------------------
   always_comb begin
      state_in           = state_ff;
      pool_log2_in       = pool_log2_ff;
      leaf_log2_in       = leaf_log2_ff;
      clr_in             = clr_ff;
      action_in          = action_ff;
      size_in            = size_ff;
      target_in          = target_ff;
      k_in               = k_ff;
      idx_in             = idx_ff;
      dep_in             = dep_ff;
      nlog_in            = nlog_ff;
      base_in            = base_ff;
      sv_idx_in          = sv_idx_ff;
      sv_dep_in          = sv_dep_ff;
      sv_nlog_in         = sv_nlog_ff;
      sv_base_in         = sv_base_ff;
      got_in             = got_ff;
      cst_in             = cst_ff;
      res_status_in      = res_status_ff;
      res_offset_in      = res_offset_ff;
      res_bytes_in       = res_bytes_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_status_in      = rsp_status_ff;
      rsp_offset_in      = rsp_offset_ff;
      rsp_block_bytes_in = rsp_block_bytes_ff;
      rd_a_addr          = idx_ff;
      rd_b_addr          = idx_ff;
      mem_we             = 1'b0;
      mem_wa             = idx_ff;
      mem_wd             = bta_pkg::NODE_FREE;

      unique case (state_ff)
         bta_pkg::S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + IW'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = bta_pkg::S_IDLE;
            end
         end

         bta_pkg::S_IDLE: begin
            if (req_valid) begin
               action_in     = req_action;
               size_in       = req_request_size;
               target_in     = req_block_offset;
               k_in          = 6'd0;
               got_in        = 1'b0;
               res_status_in = bta_pkg::STAT_OK;
               res_offset_in = 32'd0;
               res_bytes_in  = 32'd0;
               state_in      = bta_pkg::S_CHECK;
            end
         end

         bta_pkg::S_CHECK: begin
            idx_in  = '0;
            dep_in  = '0;
            nlog_in = geo_pool;
            base_in = 32'd0;
            if (action_ff == bta_pkg::ACT_ALLOC) begin
               if ({1'b0, eff_size} >= (33'd1 << geo_pool)) begin
                  res_status_in = bta_pkg::STAT_TOO_LARGE;
                  state_in      = bta_pkg::S_FINISH;
               end else begin
                  size_in  = eff_size - 32'd1;
                  state_in = bta_pkg::S_SIZE;
               end
            end else begin
               if ({1'b0, target_ff} >= (33'd1 << geo_pool)) begin
                  res_status_in = bta_pkg::STAT_BAD_FREE;
                  state_in      = bta_pkg::S_FINISH;
               end else begin
                  state_in = bta_pkg::S_F_RD;
               end
            end
         end

         // Rounded size exponent: count the bits of size minus one.
         bta_pkg::S_SIZE: begin
            if (size_ff == 32'd0) begin
               state_in = bta_pkg::S_A_RD;
            end else begin
               size_in = size_ff >> 1;
               k_in    = k_ff + 6'd1;
            end
         end

         bta_pkg::S_A_RD: begin
            state_in = bta_pkg::S_A_EVAL;
         end

         bta_pkg::S_A_EVAL: begin
            if ((rd_a_ff == bta_pkg::NODE_OCC) || (rd_a_ff == bta_pkg::NODE_CHOCC)) begin
               got_in   = 1'b0;
               state_in = bta_pkg::S_A_UP;
            end else if (rd_a_ff == bta_pkg::NODE_FREE) begin
               sv_idx_in  = idx_ff;
               sv_dep_in  = dep_ff;
               sv_nlog_in = nlog_ff;
               sv_base_in = base_ff;
               state_in   = bta_pkg::S_A_FREE;
            end else if (!want_split || (nlog_ff <= geo_leaf) || at_bottom) begin
               got_in   = 1'b0;
               state_in = bta_pkg::S_A_UP;
            end else begin
               idx_in   = left_idx;
               dep_in   = dep_ff + DW'(1);
               nlog_in  = nlog_ff - 6'd1;
               state_in = bta_pkg::S_A_RD;
            end
         end

         // The current node is known free: split it or take it.
         bta_pkg::S_A_FREE: begin
            mem_we = 1'b1;
            if ((nlog_ff != geo_leaf) && want_split && !at_bottom) begin
               mem_wd   = bta_pkg::NODE_SPLIT;
               state_in = bta_pkg::S_A_WR_L;
            end else begin
               mem_wd        = bta_pkg::NODE_OCC;
               res_offset_in = base_ff;
               res_bytes_in  = node_bytes;
               got_in        = 1'b1;
               idx_in        = sv_idx_ff;
               dep_in        = sv_dep_ff;
               nlog_in       = sv_nlog_ff;
               base_in       = sv_base_ff;
               state_in      = bta_pkg::S_A_UP;
            end
         end

         bta_pkg::S_A_WR_L: begin
            mem_we   = 1'b1;
            mem_wa   = left_idx;
            state_in = bta_pkg::S_A_WR_R;
         end

         bta_pkg::S_A_WR_R: begin
            mem_we   = 1'b1;
            mem_wa   = right_idx;
            idx_in   = left_idx;
            dep_in   = dep_ff + DW'(1);
            nlog_in  = nlog_ff - 6'd1;
            state_in = bta_pkg::S_A_FREE;
         end

         // The current node has returned got_ff to its parent.
         bta_pkg::S_A_UP: begin
            if (dep_ff == '0) begin
               res_status_in = got_ff ? bta_pkg::STAT_OK : bta_pkg::STAT_NO_SPACE;
               state_in      = bta_pkg::S_FINISH;
            end else if (!got_ff && idx_ff[0]) begin
               idx_in   = idx_ff + IW'(1);
               base_in  = base_ff | node_bit;
               state_in = bta_pkg::S_A_RD;
            end else begin
               idx_in   = parent_idx;
               dep_in   = dep_ff - DW'(1);
               nlog_in  = nlog_ff + 6'd1;
               base_in  = base_ff & ~node_bit;
               state_in = bta_pkg::S_A_CHK_RD;
            end
         end

         bta_pkg::S_A_CHK_RD: begin
            rd_a_addr = left_idx;
            rd_b_addr = right_idx;
            state_in  = bta_pkg::S_A_CHK;
         end

         bta_pkg::S_A_CHK: begin
            if (rd_a_full && rd_b_full) begin
               mem_we = 1'b1;
               mem_wd = bta_pkg::NODE_CHOCC;
            end
            state_in = bta_pkg::S_A_UP;
         end

         bta_pkg::S_F_RD: begin
            state_in = bta_pkg::S_F_EVAL;
         end

         bta_pkg::S_F_EVAL: begin
            if (rd_a_ff == bta_pkg::NODE_OCC) begin
               mem_we        = 1'b1;
               cst_in        = bta_pkg::NODE_FREE;
               res_offset_in = base_ff;
               res_bytes_in  = node_bytes;
               state_in      = (dep_ff == '0) ? bta_pkg::S_FINISH : bta_pkg::S_F_UP_RD;
            end else if ((rd_a_ff == bta_pkg::NODE_FREE) || (nlog_ff <= geo_leaf) ||
                         at_bottom) begin
               res_status_in = bta_pkg::STAT_BAD_FREE;
               state_in      = bta_pkg::S_FINISH;
            end else begin
               idx_in   = tgt_bit ? right_idx : left_idx;
               base_in  = tgt_bit ? (base_ff | half_bit) : base_ff;
               dep_in   = dep_ff + DW'(1);
               nlog_in  = nlog_ff - 6'd1;
               state_in = bta_pkg::S_F_RD;
            end
         end

         bta_pkg::S_F_UP_RD: begin
            rd_a_addr = sib_idx;
            rd_b_addr = parent_idx;
            state_in  = bta_pkg::S_F_UP;
         end

         // Port A holds the buddy, port B the parent.
         bta_pkg::S_F_UP: begin
            mem_wa = parent_idx;
            if ((cst_ff == bta_pkg::NODE_FREE) && (rd_a_ff == bta_pkg::NODE_FREE)) begin
               mem_we = 1'b1;
               mem_wd = bta_pkg::NODE_FREE;
               cst_in = bta_pkg::NODE_FREE;
            end else if (rd_b_ff != bta_pkg::NODE_SPLIT) begin
               mem_we = 1'b1;
               mem_wd = bta_pkg::NODE_SPLIT;
               cst_in = bta_pkg::NODE_SPLIT;
            end
            idx_in = parent_idx;
            dep_in = dep_ff - DW'(1);
            if (!mem_we || (dep_ff == DW'(1))) begin
               state_in = bta_pkg::S_FINISH;
            end else begin
               state_in = bta_pkg::S_F_UP_RD;
            end
         end

         bta_pkg::S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_status_in      = res_status_ff;
               rsp_offset_in      = res_offset_ff;
               rsp_block_bytes_in = res_bytes_ff;
               state_in           = bta_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = bta_pkg::S_CLEAR;
            clr_in   = '0;
         end
      endcase

      // A configuration write replaces the geometry and drops every block,
      // so the tree is cleared again. Unknown indexes are ignored.
      if (csr_write_en) begin
         if (csr_index == bta_pkg::CSR_POOL_LOG2) begin
            pool_log2_in = csr_wdata;
            state_in     = bta_pkg::S_CLEAR;
            clr_in       = '0;
         end else if (csr_index == bta_pkg::CSR_LEAF_LOG2) begin
            leaf_log2_in = csr_wdata;
            state_in     = bta_pkg::S_CLEAR;
            clr_in       = '0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Control registers.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bta_pkg::S_CLEAR;
         clr_ff       <= '0;
         pool_log2_ff <= bta_pkg::POOL_LOG2_RST;
         leaf_log2_ff <= bta_pkg::LEAF_LOG2_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pool_log2_ff <= pool_log2_in;
         leaf_log2_ff <= leaf_log2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------------------------
   // Payload and walk registers.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      action_ff          <= action_in;
      size_ff            <= size_in;
      target_ff          <= target_in;
      k_ff               <= k_in;
      idx_ff             <= idx_in;
      dep_ff             <= dep_in;
      nlog_ff            <= nlog_in;
      base_ff            <= base_in;
      sv_idx_ff          <= sv_idx_in;
      sv_dep_ff          <= sv_dep_in;
      sv_nlog_ff         <= sv_nlog_in;
      sv_base_ff         <= sv_base_in;
      got_ff             <= got_in;
      cst_ff             <= cst_in;
      res_status_ff      <= res_status_in;
      res_offset_ff      <= res_offset_in;
      res_bytes_ff       <= res_bytes_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_offset_ff      <= rsp_offset_in;
      rsp_block_bytes_ff <= rsp_block_bytes_in;
   end

   // A request transaction is taken only between walks, and a finished
   // result waits in the response register while the next one is accepted.
   assign req_stall       = state_ff != bta_pkg::S_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_offset      = rsp_offset_ff;
   assign rsp_block_bytes = rsp_block_bytes_ff;

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the buddy tree allocator. A short table of directed
// transactions covers the size and offset extremes, every status code, the
// whole-pool grant and the register clamping rules. Several phases of random
// allocate and free traffic follow, each under its own pool and leaf sizes.
// Every response is checked against the fixed expectation of its table row or
// against a behavioral copy of the buddy tree kept here.
// ----------------------------------------------------------------------------
module tb_top;
   import bta_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEVELS     = LEVELS_DEF;
   localparam int TREE_NODES = (2 << LEVELS) - 1;

   // A configuration write starts a clearing pass over every node, so the
   // bench keeps the write port quiet for longer than that pass.
   localparam int CLEAR_WAIT = TREE_NODES + 16;

   // The slowest legal allocate backtracks over a large part of the tree, and
   // the response side may stall on top of that. The watchdog budget is still
   // far above any correct run.
   localparam int CYCLE_LIMIT = 4_000_000;

   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 128;
   localparam int NUM_ROWS    = 28;

   // Index with no register behind it; writes to it must be ignored.
   localparam logic [1:0] CSR_SPARE = 2'd3;

   // One response of the block.
   typedef struct packed {
      status_type  status;
      logic [31:0] offset;
      logic [31:0] bytes;
   } grant_t;

   // A block currently owned by the bench; bytes is saturated like the port.
   typedef struct packed {
      logic [31:0] base;
      logic [31:0] bytes;
   } block_t;

   typedef enum logic [1:0] {
      ROW_CSR,
      ROW_ALLOC,
      ROW_FREE
   } row_kind_t;

   // One line of the directed table. For CSR rows sel picks the register and
   // arg carries the data; otherwise arg is the size or the offset. When typed
   // is set the response must equal want, else the tree model decides.
   typedef struct packed {
      row_kind_t   kind;
      logic [1:0]  sel;
      logic [31:0] arg;
      bit          typed;
      grant_t      want;
   } step_t;

   localparam grant_t UNTYPED = '{STAT_OK, 32'd0, 32'd0};

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_action = ACT_ALLOC;
   logic [31:0] req_request_size = 32'd0;
   logic [31:0] req_block_offset = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_offset;
   logic [31:0] rsp_block_bytes;
   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_index = CSR_POOL_LOG2;
   logic [5:0]  csr_wdata = 6'd0;

   // Bench copy of the allocator: node codes in heap order plus registers.
   node_type    tree_state [TREE_NODES];
   logic [5:0]  pool_reg;
   logic [5:0]  leaf_reg;

   grant_t      grants_due [$];
   block_t      held_blocks [$];
   int          err_count = 0;
   int          cycle_count = 0;
   bit          steady = 1'b0;

   // Directed table. Rows run in order against the state the earlier rows
   // leave behind; the comments give the geometry in force.
   step_t script [NUM_ROWS] = '{
      // Reset geometry: 64 KiB pool, 256 byte leaves.
      '{ROW_ALLOC, CSR_POOL_LOG2, 32'd0,          1'b1, '{STAT_OK, 32'd0, 32'd256}},
      '{ROW_ALLOC, CSR_POOL_LOG2, 32'd65536,      1'b1, '{STAT_TOO_LARGE, 32'd0, 32'd0}},
      '{ROW_ALLOC, CSR_POOL_LOG2, 32'hFFFF_FFFF,  1'b1, '{STAT_TOO_LARGE, 32'd0, 32'd0}},
      '{ROW_ALLOC, CSR_POOL_LOG2, 32'd32768,      1'b0, UNTYPED},
      '{ROW_ALLOC, CSR_POOL_LOG2, 32'd32769,      1'b1, '{STAT_NO_SPACE, 32'd0, 32'd0}},
      '{ROW_FREE,  CSR_POOL_LOG2, 32'd65536,      1'b1, '{STAT_BAD_FREE, 32'd0, 32'd0}},
      '{ROW_FREE,  CSR_POOL_LOG2, 32'hFFFF_FFFF,  1'b1, '{STAT_BAD_FREE, 32'd0, 32'd0}},
      '{ROW_FREE,  CSR_POOL_LOG2, 32'd300,        1'b0, UNTYPED},
      '{ROW_FREE,  CSR_POOL_LOG2, 32'd255,        1'b0, UNTYPED},
      '{ROW_FREE,  CSR_POOL_LOG2, 32'd0,          1'b0, UNTYPED},
      '{ROW_FREE,  CSR_POOL_LOG2, 32'h0000_ABCD,  1'b0, UNTYPED},
      // Pool code zero is taken as a two byte pool with a single node in use.
      '{ROW_CSR,   CSR_POOL_LOG2, 32'd0,          1'b0, UNTYPED},
      '{ROW_ALLOC, CSR_POOL_LOG2, 32'd1,          1'b1, '{STAT_OK, 32'd0, 32'd2}},
      '{ROW_ALLOC, CSR_POOL_LOG2, 32'd2,          1'b1, '{STAT_TOO_LARGE, 32'd0, 32'd0}},
      '{ROW_ALLOC, CSR_POOL_LOG2, 32'd1,          1'b1, '{STAT_NO_SPACE, 32'd0, 32'd0}},
      '{ROW_FREE,  CSR_POOL_LOG2, 32'd1,          1'b1, '{STAT_OK, 32'd0, 32'd2}},
      // Largest pool code clamps to 4 GiB; the leaf is raised to 2^24.
      '{ROW_CSR,   CSR_POOL_LOG2, 32'd63,         1'b0, UNTYPED},
      '{ROW_CSR,   CSR_SPARE,     32'd42,         1'b0, UNTYPED},
      '{ROW_ALLOC, CSR_POOL_LOG2, 32'hFFFF_FFFF,  1'b1, '{STAT_OK, 32'd0, 32'hFFFF_FFFF}},
      '{ROW_FREE,  CSR_POOL_LOG2, 32'hFFFF_FFFF,  1'b1, '{STAT_OK, 32'd0, 32'hFFFF_FFFF}},
      // Leaf above the pool is lowered to it, so any request takes it all.
      '{ROW_CSR,   CSR_LEAF_LOG2, 32'd63,         1'b0, UNTYPED},
      '{ROW_ALLOC, CSR_POOL_LOG2, 32'd0,          1'b1, '{STAT_OK, 32'd0, 32'hFFFF_FFFF}},
      '{ROW_ALLOC, CSR_POOL_LOG2, 32'd0,          1'b1, '{STAT_NO_SPACE, 32'd0, 32'd0}},
      // 1 MiB pool with leaf code zero, raised to the deepest level.
      '{ROW_CSR,   CSR_POOL_LOG2, 32'd20,         1'b0, UNTYPED},
      '{ROW_CSR,   CSR_LEAF_LOG2, 32'd0,          1'b0, UNTYPED},
      '{ROW_ALLOC, CSR_POOL_LOG2, 32'd1,          1'b0, UNTYPED},
      '{ROW_ALLOC, CSR_POOL_LOG2, 32'd3000,       1'b0, UNTYPED},
      '{ROW_FREE,  CSR_POOL_LOG2, 32'h000F_FFFF,  1'b0, UNTYPED}
   };

   buddy_tree_allocator u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_request_size (req_request_size),
      .req_block_offset (req_block_offset),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_offset       (rsp_offset),
      .rsp_block_bytes  (rsp_block_bytes),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Effective pool and leaf exponents after the register clamping rules.
   function automatic void tree_geometry(output int unsigned p, output int unsigned lf);
      p  = pool_reg;
      lf = leaf_reg;
      if (p < 1) p = 1;
      if (p > 32) p = 32;
      if (lf + LEVELS < p) lf = p - LEVELS;
      if (lf > p) lf = p;
   endfunction

   // Depth-first, left-first search for a block of 2^k bytes. The walk keeps
   // an explicit stack of frames; a frame in step 1 is waiting on its left
   // child and one in step 2 on its right child. Splitting a free node hands
   // the search straight to its left child, which then answers for both.
   function automatic bit claim_block(int unsigned k, int unsigned top_log,
                                      int unsigned lf, output logic [63:0] off,
                                      output logic [63:0] bytes);
      int unsigned f_idx  [LEVELS+1];
      int unsigned f_log  [LEVELS+1];
      logic [63:0] f_base [LEVELS+1];
      int unsigned f_step [LEVELS+1];
      int          d;
      int unsigned i, lc, rc;
      bit          got, unwinding;
      off = 64'd0;
      bytes = 64'd0;
      got = 1'b0;
      unwinding = 1'b0;
      d = 0;
      f_idx[0] = 0;
      f_log[0] = top_log;
      f_base[0] = 64'd0;
      f_step[0] = 0;
      while (d >= 0) begin
         i  = f_idx[d];
         lc = 2 * i + 1;
         rc = 2 * i + 2;
         if (unwinding) begin
            if (f_step[d] == 1 && !got) begin
               // Left subtree had no room: try the right buddy.
               f_step[d] = 2;
               unwinding = 1'b0;
               d++;
               f_idx[d]  = rc;
               f_log[d]  = f_log[d-1] - 1;
               f_base[d] = f_base[d-1] + (64'd1 << f_log[d]);
               f_step[d] = 0;
            end else begin
               if (tree_state[lc] >= NODE_OCC && tree_state[rc] >= NODE_OCC)
                  tree_state[i] = NODE_CHOCC;
               d--;
            end
         end else if (tree_state[i] >= NODE_OCC) begin
            got = 1'b0;
            unwinding = 1'b1;
            d--;
         end else if (tree_state[i] == NODE_FREE) begin
            if (f_log[d] != lf && f_log[d] > k && rc < TREE_NODES) begin
               tree_state[lc] = NODE_FREE;
               tree_state[rc] = NODE_FREE;
               tree_state[i]  = NODE_SPLIT;
               f_idx[d] = lc;
               f_log[d] = f_log[d] - 1;
            end else begin
               tree_state[i] = NODE_OCC;
               off   = f_base[d];
               bytes = 64'd1 << f_log[d];
               got = 1'b1;
               unwinding = 1'b1;
               d--;
            end
         end else if (f_log[d] <= k || f_log[d] <= lf || rc >= TREE_NODES) begin
            got = 1'b0;
            unwinding = 1'b1;
            d--;
         end else begin
            f_step[d] = 1;
            d++;
            f_idx[d]  = lc;
            f_log[d]  = f_log[d-1] - 1;
            f_base[d] = f_base[d-1];
            f_step[d] = 0;
         end
      end
      return got;
   endfunction

   // Applies one request to the bench tree and returns the response it owes.
   function automatic grant_t compute_grant(logic act, logic [31:0] req_size,
                                            logic [31:0] target);
      grant_t      g;
      int unsigned p, lf, k, idx, nlog, par;
      logic [63:0] pool, sz, base, half, off, bytes;
      bit          bad;
      tree_geometry(p, lf);
      pool  = 64'd1 << p;
      g     = UNTYPED;
      off   = 64'd0;
      bytes = 64'd0;
      if (act == ACT_ALLOC) begin
         sz = (req_size == 32'd0) ? 64'd1 : {32'd0, req_size};
         if (sz >= pool) begin
            g.status = STAT_TOO_LARGE;
         end else begin
            k = 0;
            while ((64'd1 << k) < sz) k++;
            if (!claim_block(k, p, lf, off, bytes)) begin
               g.status = STAT_NO_SPACE;
               off   = 64'd0;
               bytes = 64'd0;
            end
         end
      end else begin
         // Walk down by offset to the occupied node that covers it.
         idx  = 0;
         nlog = p;
         base = 64'd0;
         bad  = {32'd0, target} >= pool;
         while (!bad && tree_state[idx] != NODE_OCC) begin
            if (tree_state[idx] == NODE_FREE || nlog <= lf || 2 * idx + 2 >= TREE_NODES) begin
               bad = 1'b1;
            end else begin
               half = 64'd1 << (nlog - 1);
               if ({32'd0, target} < base + half) begin
                  idx = 2 * idx + 1;
               end else begin
                  idx  = 2 * idx + 2;
                  base = base + half;
               end
               nlog--;
            end
         end
         if (bad) begin
            g.status = STAT_BAD_FREE;
         end else begin
            tree_state[idx] = NODE_FREE;
            off   = base;
            bytes = 64'd1 << nlog;
            // Merge free buddies upward; stop at the first parent that is
            // already marked split.
            while (idx != 0) begin
               par = (idx - 1) / 2;
               if (tree_state[2*par+1] == NODE_FREE && tree_state[2*par+2] == NODE_FREE)
                  tree_state[par] = NODE_FREE;
               else if (tree_state[par] != NODE_SPLIT)
                  tree_state[par] = NODE_SPLIT;
               else
                  break;
               idx = par;
            end
         end
      end
      g.offset = off[31:0];
      g.bytes  = (bytes > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : bytes[31:0];
      return g;
   endfunction

   // Register write as seen by the bench tree: any known index drops all
   // blocks, an unknown index changes nothing.
   function automatic void apply_csr(logic [1:0] sel, logic [5:0] data);
      if (sel == CSR_POOL_LOG2)
         pool_reg = data;
      else if (sel == CSR_LEAF_LOG2)
         leaf_reg = data;
      else
         return;
      foreach (tree_state[n]) tree_state[n] = NODE_FREE;
      held_blocks.delete();
   endfunction

   // Predicts the response, queues it and presents the request until it is
   // taken. Valid is left high so back-to-back transactions need no gap.
   task automatic issue(input logic act, input logic [31:0] req_size,
                        input logic [31:0] target, input bit typed, input grant_t want);
      grant_t g;
      int     hit;
      g = compute_grant(act, req_size, target);
      if (g.status == STAT_OK) begin
         if (act == ACT_ALLOC) begin
            held_blocks.push_back('{g.offset, g.bytes});
         end else begin
            hit = -1;
            for (int j = 0; j < held_blocks.size(); j++)
               if (held_blocks[j].base == g.offset) hit = j;
            if (hit >= 0) held_blocks.delete(hit);
         end
      end
      grants_due.push_back(typed ? want : g);
      req_valid        <= 1'b1;
      req_action       <= act;
      req_request_size <= req_size;
      req_block_offset <= target;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Random sender gap, skipped during the steady stretch.
   task automatic pause_sender();
      if (!steady && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Holds off the sender until every queued response has come back.
   task automatic settle();
      req_valid <= 1'b0;
      while (grants_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // The quiet wait up front lets any request or clearing pass finish first.
   task automatic write_csr(input logic [1:0] sel, input logic [5:0] data);
      repeat (CLEAR_WAIT) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= sel;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      apply_csr(sel, data);
   endtask

   // Response checker and random response stall. Outputs are read right
   // after the edge, so they hold the values the edge itself sampled.
   always @(posedge clock) begin
      grant_t due;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (grants_due.size() == 0) begin
               $error("response with no transaction outstanding: status %0d offset %h",
                      rsp_status, rsp_offset);
               err_count++;
            end else begin
               due = grants_due.pop_front();
               if (rsp_status !== due.status) begin
                  $error("status: expected %0d, got %0d", due.status, rsp_status);
                  err_count++;
               end
               if (rsp_offset !== due.offset) begin
                  $error("offset: expected %h, got %h", due.offset, rsp_offset);
                  err_count++;
               end
               if (rsp_block_bytes !== due.bytes) begin
                  $error("block_bytes: expected %h, got %h", due.bytes, rsp_block_bytes);
                  err_count++;
               end
            end
         end
         rsp_stall <= !steady && ($urandom_range(0, 99) < 25);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      step_t       row;
      block_t      blk;
      int unsigned p, lf, k, pick, drop;
      logic        act;
      logic [31:0] req_size, target, mask;
      logic [63:0] lo, hi;
      int          pool_pick, leaf_pick;

      pool_reg = POOL_LOG2_RST;
      leaf_reg = LEAF_LOG2_RST;
      foreach (tree_state[n]) tree_state[n] = NODE_FREE;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed table.
      for (int n = 0; n < NUM_ROWS; n++) begin
         row = script[n];
         if (row.kind == ROW_CSR) begin
            settle();
            write_csr(row.sel, row.arg[5:0]);
         end else begin
            issue((row.kind == ROW_FREE) ? ACT_FREE : ACT_ALLOC, row.arg, row.arg,
                  row.typed, row.want);
            pause_sender();
         end
      end

      // Random phases. Each starts from an empty tree under a new geometry.
      // Most transactions allocate realistic sizes or free a block that is
      // really held, at a random byte inside it, so the tree fills, splits
      // and merges; the rest are stale frees and raw noise.
      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         steady = (ph == 4);
         pool_pick = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                 : $urandom_range(1, 32);
         drop = $urandom_range(0, 9);
         if ($urandom_range(0, 5) == 0)
            leaf_pick = $urandom_range(0, 63);
         else
            leaf_pick = (pool_pick > drop) ? pool_pick - drop : 0;
         write_csr(CSR_POOL_LOG2, pool_pick[5:0]);
         write_csr(CSR_LEAF_LOG2, leaf_pick[5:0]);
         tree_geometry(p, lf);
         mask = (p >= 32) ? 32'hFFFF_FFFF : (32'd1 << p) - 32'd1;

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            req_size = $urandom;
            target   = $urandom;
            if (pick < 8) begin
               act = $urandom_range(0, 1);
            end else if (pick < 14) begin
               // Offset inside the pool that may or may not be held.
               act = ACT_FREE;
               target = target & mask;
            end else if (pick < 50 && held_blocks.size() != 0) begin
               act = ACT_FREE;
               blk = held_blocks[$urandom_range(0, held_blocks.size() - 1)];
               target = blk.base + $urandom_range(0, blk.bytes - 32'd1);
            end else begin
               act = ACT_ALLOC;
               k = $urandom_range(0, p);
               if (k == 0) begin
                  req_size = $urandom_range(0, 1);
               end else begin
                  lo = (64'd1 << (k - 1)) + 64'd1;
                  hi = (k >= 32) ? 64'hFFFF_FFFF : (64'd1 << k);
                  req_size = $urandom_range(lo[31:0], hi[31:0]);
               end
            end
            issue(act, req_size, target, 1'b0, UNTYPED);
            // Now and then the sender waits for the block to run dry.
            if (!steady && $urandom_range(0, 63) == 0)
               settle();
            else
               pause_sender();
         end
      end

      settle();
      repeat (64) @(posedge clock);
      if (err_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

>>> sim.f
design/bta_pkg.sv
design/buddy_tree_allocator.sv
tb/sv/tb_top.sv
